// ----- rtl/core/mprm_pkg.sv -----
package mprm_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PROG_W       = 4;
  localparam int unsigned CODE_W       = 3;
  localparam int unsigned TABLE_WORDS  = 6;
  localparam int unsigned MAX_WORD_LEN = 9;
  localparam int unsigned NUM_WORDS_DEF = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [PROG_W-1:0] prog_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic step;
    logic clear;
  } lane_ctrl_t;

  // reply words, unused tail positions are zero
  localparam byte_t WORD_CHARS [TABLE_WORDS][MAX_WORD_LEN] = '{
    '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "a", "d", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "A", "I", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "o", " ", "c", "h", "a", "n", "g", "e"},
    '{"L", "i", "n", "k", "e", "d", 8'h00, 8'h00, 8'h00},
    '{"U", "n", "l", "i", "n", "k", 8'h00, 8'h00, 8'h00}
  };

  localparam prog_t WORD_LENS [TABLE_WORDS] = '{
    PROG_W'(2), PROG_W'(5), PROG_W'(4), PROG_W'(9), PROG_W'(6), PROG_W'(6)
  };

  // words beyond the table have length zero and never match
  function automatic prog_t word_len(int unsigned w);
    prog_t len;
    len = '0;
    if (w < TABLE_WORDS) begin
      len = WORD_LENS[w];
    end
    return len;
  endfunction

  function automatic byte_t char_at(int unsigned w, prog_t pos);
    byte_t ch;
    ch = '0;
    if (w < TABLE_WORDS) begin
      for (int unsigned k = 0; k < MAX_WORD_LEN; k++) begin
        if (pos == PROG_W'(k)) begin
          ch = WORD_CHARS[w][k];
        end
      end
    end
    return ch;
  endfunction

endpackage

// ----- rtl/core/multi_pattern_reply_matcher_core.sv -----
// path: an accepted byte is held in the input register, and a byte that completes a word
//   has its reply code written into the reply register, shown with reply_valid_o
// throughput: one byte per cycle; the lane compares and counter updates sit between
//   the input register and the reply register; only a byte that completes a word
//   waits, while an unaccepted reply is held
// reset (rst_ni low, asynchronous): all progress counters cleared, both registers empty
module multi_pattern_reply_matcher_core #(
  parameter int unsigned NUM_WORDS = mprm_pkg::NUM_WORDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mprm_pkg::byte_t rx_byte_i,
  input  logic            rx_valid_i,
  output logic            rx_ready_o,
  output mprm_pkg::code_t reply_code_o,
  output logic            reply_valid_o,
  input  logic            reply_ready_i
);
  import mprm_pkg::*;

  logic           rx_vld_q;
  byte_t          rx_byte_q;
  logic           out_vld_q;
  code_t          code_q, code_d;
  logic [NUM_WORDS-1:0] done;
  logic [NUM_WORDS-1:0] match;
  logic           hit;
  logic           advance;
  lane_ctrl_t     lane_ctrl;

  assign hit = |done;

  // a byte that completes no word never needs room in the reply register
  assign advance    = rx_vld_q && (!hit || !out_vld_q || reply_ready_i);
  assign rx_ready_o = !rx_vld_q || advance;

  assign lane_ctrl.step  = advance;
  assign lane_ctrl.clear = hit;

  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_lane
    mprm_lane #(
      .WordIdx(w)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .rx_byte_i(rx_byte_q),
      .match_o  (match[w]),
      .done_o   (done[w])
    );
  end

  // highest completed word wins
  always_comb begin
    code_d = '0;
    for (int unsigned w = 0; w < NUM_WORDS; w++) begin
      if (done[w] && match[w]) begin
        code_d = CODE_W'(w);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rx_valid_i && rx_ready_o) begin
        rx_vld_q <= 1'b1;
      end else if (advance) begin
        rx_vld_q <= 1'b0;
      end
      if (advance && hit) begin
        out_vld_q <= 1'b1;
      end else if (reply_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      rx_byte_q <= rx_byte_i;
    end
    if (advance && hit) begin
      code_q <= code_d;
    end
  end

  assign reply_valid_o = out_vld_q;
  assign reply_code_o  = code_q;

endmodule

// ----- rtl/core/mprm_lane.sv -----
module mprm_lane #(
  parameter int unsigned WordIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mprm_pkg::lane_ctrl_t ctrl_i,
  input  mprm_pkg::byte_t     rx_byte_i,
  output logic                match_o,
  output logic                done_o
);
  import mprm_pkg::*;

  localparam prog_t Len = word_len(WordIdx);

  prog_t pos_q, pos_d;
  prog_t pos_inc;

  assign pos_inc = pos_q + PROG_W'(1);
  assign match_o = (Len != '0) && (pos_q < Len) && (char_at(WordIdx, pos_q) == rx_byte_i);
  assign done_o  = match_o && (pos_inc == Len);

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.step) begin
      if (ctrl_i.clear || !match_o) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- dv/multi_pattern_reply_matcher_checker.sv -----
`timescale 1ns / 1ps
module multi_pattern_reply_matcher_checker #(
  parameter int unsigned NUM_WORDS = mprm_pkg::NUM_WORDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mprm_pkg::byte_t rx_byte_i,
  input  logic            rx_valid_i,
  input  logic            rx_ready_i,
  input  mprm_pkg::code_t reply_code_i,
  input  logic            reply_valid_i,
  input  logic            reply_ready_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     bytes_seen_o,
  output int unsigned     replies_seen_o
);
  import mprm_pkg::*;

  typedef enum int unsigned {
    WORD_OK,
    WORD_READY,
    WORD_FAIL,
    WORD_NO_CHANGE,
    WORD_LINKED,
    WORD_UNLINK
  } reply_word_e;

  prog_t progress [NUM_WORDS];
  code_t replies_due_q [$];

  function automatic string word_text(input int unsigned w);
    string txt;
    case (w)
      WORD_OK:        txt = "OK";
      WORD_READY:     txt = "ready";
      WORD_FAIL:      txt = "FAIL";
      WORD_NO_CHANGE: txt = "no change";
      WORD_LINKED:    txt = "Linked";
      WORD_UNLINK:    txt = "Unlink";
      default:        txt = "";
    endcase
    return txt;
  endfunction

  // advances every word on one byte; a mismatch drops the word back to zero
  // without trying the byte again as a first character
  function automatic bit consume_byte(input byte_t ch, output code_t code);
    string       txt;
    int unsigned len;
    int unsigned pos;
    bit          hit;
    hit  = 1'b0;
    code = '0;
    for (int unsigned w = 0; w < NUM_WORDS; w++) begin
      txt = word_text(w);
      len = txt.len();
      pos = progress[w];
      if (len != 0 && pos < len && byte_t'(txt[pos]) == ch) begin
        progress[w] = prog_t'(pos + 1);
        // later words overwrite, so the highest index wins
        if (pos + 1 == len) begin
          hit  = 1'b1;
          code = code_t'(w);
        end
      end else begin
        progress[w] = '0;
      end
    end
    if (hit) begin
      foreach (progress[i]) progress[i] = '0;
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    code_t new_code;
    code_t due_code;
    if (!rst_ni) begin
      foreach (progress[i]) progress[i] = '0;
      replies_due_q.delete();
      pending_o <= 0;
    end else begin
      if (rx_valid_i && rx_ready_i) begin
        bytes_seen_o++;
        if (consume_byte(rx_byte_i, new_code)) begin
          replies_due_q.push_back(new_code);
        end
      end
      if (reply_valid_i && reply_ready_i) begin
        replies_seen_o++;
        if (replies_due_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: reply_code expected none, got %0d", $time, reply_code_i);
        end else begin
          due_code = replies_due_q.pop_front();
          if (reply_code_i !== due_code) begin
            fail_count_o++;
            $display("%0t: reply_code expected %0d, got %0d", $time, due_code,
                     reply_code_i);
          end
        end
      end
      pending_o <= replies_due_q.size();
    end
  end

endmodule

// ----- dv/multi_pattern_reply_matcher_core_tb.sv -----
`timescale 1ns / 1ps
module multi_pattern_reply_matcher_core_tb;
  import mprm_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned TOTAL_ITEMS  = 650;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 200000;

  logic  clk_i;
  logic  rst_ni        = 1'b0;
  byte_t rx_byte_i     = '0;
  logic  rx_valid_i    = 1'b0;
  logic  rx_ready_o;
  code_t reply_code_o;
  logic  reply_valid_o;
  logic  reply_ready_i = 1'b0;

  bit          tx_no_idle   = 1'b0;
  bit          rx_no_idle   = 1'b0;
  bit          hold_replies = 1'b0;
  int unsigned bytes_sent   = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_seen;
  int unsigned replies_seen;

  multi_pattern_reply_matcher_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .reply_code_o (reply_code_o),
    .reply_valid_o(reply_valid_o),
    .reply_ready_i(reply_ready_i)
  );

  multi_pattern_reply_matcher_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_i    (rx_ready_o),
    .reply_code_i  (reply_code_o),
    .reply_valid_i (reply_valid_o),
    .reply_ready_i (reply_ready_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .bytes_seen_o  (bytes_seen),
    .replies_seen_o(replies_seen)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  task automatic send_byte(input byte_t ch);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_byte_i  <= ch;
    rx_valid_i <= 1'b1;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string txt);
    foreach (txt[k]) send_byte(byte_t'(txt[k]));
  endtask

  // a broken word has one character swapped for a random byte
  task automatic send_word(input int unsigned w, input bit broken);
    int unsigned len;
    int unsigned bad_pos;
    len     = WORD_LENS[w];
    bad_pos = broken ? $urandom_range(0, len - 1) : len;
    for (int unsigned k = 0; k < len; k++) begin
      if (k == bad_pos) send_byte(byte_t'($urandom_range(0, 255)));
      else send_byte(WORD_CHARS[w][k]);
    end
  endtask

  // noise is either any byte or a stray character from one of the words
  task automatic send_noise();
    int unsigned w;
    byte_t       ch;
    w = $urandom_range(0, TABLE_WORDS - 1);
    if ($urandom_range(0, 1) == 0) ch = byte_t'($urandom_range(0, 255));
    else ch = WORD_CHARS[w][$urandom_range(0, WORD_LENS[w] - 1)];
    send_byte(ch);
  endtask

  task automatic wait_replies_drained();
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    bit held;
    bit paused;
    bit calm;
    held   = 1'b0;
    paused = 1'b0;
    calm   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes, a doubled first letter that must not restart the word,
    // then complete words
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("OOK");
    send_text("OK");
    send_text("ready");
    send_text("FAIL");
    send_text("Unlink");
    wait_replies_drained();

    while (bytes_sent < TOTAL_ITEMS) begin
      if (!held && bytes_sent >= 200) begin
        // receiver stalls while a burst of short words fills the pipeline
        held         = 1'b1;
        hold_replies = 1'b1;
        tx_no_idle   = 1'b1;
        repeat (40) send_text("OK");
        tx_no_idle   = 1'b0;
      end else if (!paused && bytes_sent >= 320) begin
        paused = 1'b1;
        wait_replies_drained();
      end else if (!calm && bytes_sent >= 420) begin
        calm       = 1'b1;
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        repeat (15) send_word($urandom_range(0, TABLE_WORDS - 1), 1'b0);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        send_word($urandom_range(0, TABLE_WORDS - 1), $urandom_range(0, 7) == 0);
      end else begin
        send_noise();
      end
    end

    wait_replies_drained();
    $display("covered %0d bytes: all six reply words, broken words and noise,", bytes_seen);
    $display("with a long reply stall and idle-free bursts; %0d replies checked", replies_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // reply side: a fresh gap per transaction, one long hold when asked
  initial begin
    int unsigned gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_replies) begin
        hold_replies = 1'b0;
        reply_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          reply_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      reply_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(reply_valid_o && reply_ready_i));
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: timed out with %0d replies still due", $time, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mprm_pkg.sv
rtl/core/mprm_lane.sv
rtl/core/multi_pattern_reply_matcher_core.sv
dv/multi_pattern_reply_matcher_checker.sv
dv/multi_pattern_reply_matcher_core_tb.sv
